// ----- rtl/pbnn_pkg.sv -----
// Shared widths and defaults for the point/box nearest-neighbor metric block.
package pbnn_pkg;

   // Default coordinate width of the query point and box bounds.
   localparam int COORD_BITS_DEF = 16;

   // Running sum width; sums saturate at all ones.
   localparam int SUM_BITS = 36;

   // Result width; results saturate at all ones.
   localparam int OUT_BITS = 35;

   // Signed width of the per-dimension face delta and its running minimum.
   localparam int DELTA_BITS = 33;

endpackage

// ----- rtl/point_box_nn_distance_metrics.sv -----
// Streaming MINDIST / MINMAXDIST between a query point and a box, one dimension per request.
// A pair's last dimension moves through the input, square, result and response registers.
// One request per cycle unless stalled; squares are registered before the running sums.
// The response register and a result holding stage let requests keep flowing while a
// response waits, until both are full.
// Reset (synchronous, active high) empties the pipeline and clears the running sums and minimum.
module point_box_nn_distance_metrics #(
   parameter int COORD_BITS = pbnn_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_coord,
   input  logic signed [COORD_BITS-1:0]  req_box_low,
   input  logic signed [COORD_BITS-1:0]  req_box_high,
   input  logic                          req_last_dim,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pbnn_pkg::OUT_BITS-1:0] rsp_min_dist_sq,
   output logic [pbnn_pkg::OUT_BITS-1:0] rsp_min_max_dist_sq
);
   import pbnn_pkg::*;

   // Working widths.
   localparam int EW  = COORD_BITS + 2;          // holds 2*coord and low+high
   localparam int SQW = 2 * COORD_BITS + 2;      // square of a coordinate difference
   localparam int DLW = SQW + 1;                 // signed difference of two squares
   localparam int SW  = (DLW > DELTA_BITS + 1) ? DLW : DELTA_BITS + 1;
   localparam int AW  = ((SQW > SUM_BITS) ? SQW : SUM_BITS) + 1;
   localparam int MW  = SUM_BITS + 2;            // far sum plus signed minimum

   localparam logic signed [SW-1:0] DMAX =
      {{(SW-DELTA_BITS+1){1'b0}}, {(DELTA_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] DMIN =
      {{(SW-DELTA_BITS+1){1'b1}}, {(DELTA_BITS-1){1'b0}}};
   localparam logic [DELTA_BITS-1:0] BEST_RESET = {1'b0, {(DELTA_BITS-1){1'b1}}};
   localparam logic [AW-1:0] SUM_MAX_W = {{(AW-SUM_BITS){1'b0}}, {SUM_BITS{1'b1}}};
   localparam logic [SUM_BITS-1:0] NEAR_OUT_MAX = {1'b0, {OUT_BITS{1'b1}}};
   localparam logic signed [MW-1:0] MM_MAX = {3'b000, {OUT_BITS{1'b1}}};

   // Pipeline registers.
   logic                          v1_ff, v1_in;
   logic signed [COORD_BITS-1:0]  coord_ff, low_ff, high_ff;
   logic                          last1_ff;
   logic                          v2_ff, v2_in;
   logic [SQW-1:0]                sq_clamp_ff, sq_far_ff, sq_near_ff;
   logic                          last2_ff;
   logic [SUM_BITS-1:0]           near_sum_ff, near_sum_in;
   logic [SUM_BITS-1:0]           far_sum_ff, far_sum_in;
   logic signed [DELTA_BITS-1:0]  best_ff, best_in;
   logic                          v3_ff, v3_in;
   logic [SUM_BITS-1:0]           res_near_ff, res_far_ff;
   logic signed [DELTA_BITS-1:0]  res_best_ff;
   logic                          v4_ff, v4_in;
   logic [OUT_BITS-1:0]           out_near_ff, out_mm_ff;

   // Handshake flow between stages.
   logic rdy1, rdy2, rdy3, rdy4, move2, load3;

   assign rdy4  = !v4_ff || !rsp_stall;
   assign rdy3  = !v3_ff || rdy4;
   assign rdy2  = !v2_ff || !last2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign move2 = v2_ff && rdy2;
   assign load3 = move2 && last2_ff;

   assign req_stall = !rdy1;
   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = load3 ? 1'b1 : (rdy4 ? 1'b0 : v3_ff);
   assign v4_in = (v3_ff && rdy4) ? 1'b1 : (rsp_stall ? v4_ff : 1'b0);

   // Stage 1: clamp point, choose near and far faces, form the three squares.
   logic signed [EW-1:0] p_x, lo_x, hi_x, clamp_x, far_x, near_x, twop_x, mid_x;
   logic signed [EW-1:0] d_clamp, d_far, d_near;
   logic [COORD_BITS:0]  a_clamp, a_far, a_near;

   always_comb begin
      p_x    = EW'(coord_ff);
      lo_x   = EW'(low_ff);
      hi_x   = EW'(high_ff);
      twop_x = p_x <<< 1;
      mid_x  = lo_x + hi_x;
      if (p_x < lo_x) begin
         clamp_x = lo_x;
      end else if (p_x > hi_x) begin
         clamp_x = hi_x;
      end else begin
         clamp_x = p_x;
      end
      far_x   = (twop_x >= mid_x) ? lo_x : hi_x;
      near_x  = (twop_x <= mid_x) ? lo_x : hi_x;
      d_clamp = p_x - clamp_x;
      d_far   = p_x - far_x;
      d_near  = p_x - near_x;
      a_clamp = d_clamp[EW-1] ? (COORD_BITS+1)'(-d_clamp) : (COORD_BITS+1)'(d_clamp);
      a_far   = d_far[EW-1]   ? (COORD_BITS+1)'(-d_far)   : (COORD_BITS+1)'(d_far);
      a_near  = d_near[EW-1]  ? (COORD_BITS+1)'(-d_near)  : (COORD_BITS+1)'(d_near);
   end

   // Stage 2: saturated accumulation and running minimum of the face delta.
   logic signed [DLW-1:0]        delta;
   logic signed [SW-1:0]         delta_w;
   logic signed [DELTA_BITS-1:0] delta_sat;
   logic [AW-1:0]                near_add, far_add;
   logic [SUM_BITS-1:0]          near_next, far_next;
   logic signed [DELTA_BITS-1:0] best_next;

   always_comb begin
      delta   = $signed({1'b0, sq_near_ff}) - $signed({1'b0, sq_far_ff});
      delta_w = SW'(delta);
      if (delta_w > DMAX) begin
         delta_sat = DELTA_BITS'(DMAX);
      end else if (delta_w < DMIN) begin
         delta_sat = DELTA_BITS'(DMIN);
      end else begin
         delta_sat = DELTA_BITS'(delta_w);
      end
      near_add  = AW'(near_sum_ff) + AW'(sq_clamp_ff);
      far_add   = AW'(far_sum_ff) + AW'(sq_far_ff);
      near_next = (near_add > SUM_MAX_W) ? {SUM_BITS{1'b1}} : near_add[SUM_BITS-1:0];
      far_next  = (far_add > SUM_MAX_W) ? {SUM_BITS{1'b1}} : far_add[SUM_BITS-1:0];
      best_next = (delta_sat < best_ff) ? delta_sat : best_ff;

      near_sum_in = near_sum_ff;
      far_sum_in  = far_sum_ff;
      best_in     = best_ff;
      if (move2) begin
         if (last2_ff) begin
            near_sum_in = '0;
            far_sum_in  = '0;
            best_in     = BEST_RESET;
         end else begin
            near_sum_in = near_next;
            far_sum_in  = far_next;
            best_in     = best_next;
         end
      end
   end

   // Stage 3: combine the far sum with the minimum delta and saturate the results.
   logic signed [MW-1:0] mm;
   logic [OUT_BITS-1:0]  mm_out, near_out;

   always_comb begin
      mm = $signed({2'b00, res_far_ff}) + MW'(res_best_ff);
      if (mm < 0) begin
         mm_out = '0;
      end else if (mm > MM_MAX) begin
         mm_out = {OUT_BITS{1'b1}};
      end else begin
         mm_out = mm[OUT_BITS-1:0];
      end
      near_out = (res_near_ff > NEAR_OUT_MAX) ? {OUT_BITS{1'b1}} : res_near_ff[OUT_BITS-1:0];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         near_sum_ff <= '0;
         far_sum_ff  <= '0;
         best_ff     <= BEST_RESET;
      end else begin
         v1_ff       <= v1_in;
         v2_ff       <= v2_in;
         v3_ff       <= v3_in;
         v4_ff       <= v4_in;
         near_sum_ff <= near_sum_in;
         far_sum_ff  <= far_sum_in;
         best_ff     <= best_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (rdy1) begin
         coord_ff <= req_coord;
         low_ff   <= req_box_low;
         high_ff  <= req_box_high;
         last1_ff <= req_last_dim;
      end
      if (rdy2) begin
         sq_clamp_ff <= SQW'(a_clamp) * SQW'(a_clamp);
         sq_far_ff   <= SQW'(a_far) * SQW'(a_far);
         sq_near_ff  <= SQW'(a_near) * SQW'(a_near);
         last2_ff    <= last1_ff;
      end
      if (load3) begin
         res_near_ff <= near_next;
         res_far_ff  <= far_next;
         res_best_ff <= best_next;
      end
      if (v3_ff && rdy4) begin
         out_near_ff <= near_out;
         out_mm_ff   <= mm_out;
      end
   end

   assign rsp_valid           = v4_ff;
   assign rsp_min_dist_sq     = out_near_ff;
   assign rsp_min_max_dist_sq = out_mm_ff;

endmodule

// ----- sim/tb.sv -----
// Testbench for the point/box MINDIST and MINMAXDIST block, with a built-in metric predictor.
`timescale 1ns / 1ps

module tb;
   import pbnn_pkg::*;

   localparam int COORD_W = COORD_BITS_DEF;
   localparam longint SUM_CAP = (longint'(1) << SUM_BITS) - 1;
   localparam longint OUT_CAP = (longint'(1) << OUT_BITS) - 1;
   localparam longint DELTA_HI = (longint'(1) << (DELTA_BITS - 1)) - 1;
   localparam longint DELTA_LO = -(longint'(1) << (DELTA_BITS - 1));
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

   typedef struct {
      logic [OUT_BITS-1:0] min_dist;
      logic [OUT_BITS-1:0] min_max_dist;
   } metrics_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_W-1:0] req_coord = '0;
   logic signed [COORD_W-1:0] req_box_low = '0;
   logic signed [COORD_W-1:0] req_box_high = '0;
   logic req_last_dim = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OUT_BITS-1:0] rsp_min_dist_sq;
   logic [OUT_BITS-1:0] rsp_min_max_dist_sq;

   // Running state of the predicted metrics for the open point-box pair.
   longint near_acc = 0;
   longint far_acc = 0;
   longint best_face_delta = DELTA_HI;
   bit dims_open = 1'b0;

   metrics_type pending_metrics[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int quiet_cycles = 0;

   point_box_nn_distance_metrics #(.COORD_BITS(COORD_W)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_coord(req_coord),
      .req_box_low(req_box_low),
      .req_box_high(req_box_high),
      .req_last_dim(req_last_dim),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_min_dist_sq(rsp_min_dist_sq),
      .rsp_min_max_dist_sq(rsp_min_max_dist_sq)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint add_saturated(input longint a, input longint b);
      return (a + b > SUM_CAP) ? SUM_CAP : a + b;
   endfunction

   // Folds one dimension into the running sums and queues the metrics on the last one.
   function automatic void accumulate_dimension(input logic signed [COORD_W-1:0] c,
                                                input logic signed [COORD_W-1:0] lo,
                                                input logic signed [COORD_W-1:0] hi,
                                                input logic last);
      longint p, l, h, clamped, near_face, far_face, far_sq, near_sq, delta, mm;
      metrics_type m;
      p = c;
      l = lo;
      h = hi;
      // Clamping checks the low bound first, which matters for an inverted box.
      if (p < l) clamped = l;
      else if (p > h) clamped = h;
      else clamped = p;
      // Exact midpoint test; a tie picks the low face for both.
      far_face = (2 * p >= l + h) ? l : h;
      near_face = (2 * p <= l + h) ? l : h;
      far_sq = (p - far_face) * (p - far_face);
      near_sq = (p - near_face) * (p - near_face);
      delta = near_sq - far_sq;
      if (delta > DELTA_HI) delta = DELTA_HI;
      if (delta < DELTA_LO) delta = DELTA_LO;
      near_acc = add_saturated(near_acc, (p - clamped) * (p - clamped));
      far_acc = add_saturated(far_acc, far_sq);
      if (delta < best_face_delta) best_face_delta = delta;
      if (!last) begin
         dims_open = 1'b1;
         return;
      end
      mm = far_acc + best_face_delta;
      if (mm < 0) mm = 0;
      m.min_dist = OUT_BITS'((near_acc > OUT_CAP) ? OUT_CAP : near_acc);
      m.min_max_dist = OUT_BITS'((mm > OUT_CAP) ? OUT_CAP : mm);
      pending_metrics.push_back(m);
      near_acc = 0;
      far_acc = 0;
      best_face_delta = DELTA_HI;
      dims_open = 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                  input logic [OUT_BITS-1:0] want);
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Offers one dimension after a random gap and holds it until the block takes it.
   task automatic send_dim(input logic signed [COORD_W-1:0] c,
                           input logic signed [COORD_W-1:0] lo,
                           input logic signed [COORD_W-1:0] hi,
                           input logic last);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_coord <= c;
      req_box_low <= lo;
      req_box_high <= hi;
      req_last_dim <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accumulate_dimension(c, lo, hi, last);
      @(negedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord();
      int k;
      k = $urandom_range(9, 0);
      if (k == 0) return COORD_MIN;
      if (k == 1) return COORD_MAX;
      if (k == 2) return ($urandom_range(1, 0) != 0) ? '0 : '1;
      if (k <= 4) return COORD_W'($urandom_range(64, 0) - 32);
      return COORD_W'($urandom());
   endfunction

   // Receiver side: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      static int hold_left = 0;
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   // Compares every accepted response with the oldest predicted metrics.
   always @(posedge clock) begin
      metrics_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_metrics.size() == 0) begin
            report_mismatch("unexpected response", rsp_min_dist_sq, '0);
         end else begin
            want = pending_metrics.pop_front();
            if (rsp_min_dist_sq !== want.min_dist)
               report_mismatch("min_dist_sq", rsp_min_dist_sq, want.min_dist);
            if (rsp_min_max_dist_sq !== want.min_max_dist)
               report_mismatch("min_max_dist_sq", rsp_min_max_dist_sq, want.min_max_dist);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: timeout with %0d responses outstanding", $time,
                  pending_metrics.size());
         $display("point_box_nn_distance_metrics test failed");
         $finish;
      end
   end

   // Field extremes, ties, inverted boxes and a multi-dimension pair.
   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct = 0;
      send_dim(16'sd0, -16'sd5, 16'sd5, 1'b1);
      send_dim(COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
      send_dim(COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
      send_dim(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
      send_dim(COORD_MIN, COORD_MIN, COORD_MAX, 1'b1);
      send_dim(16'sd0, 16'sd100, -16'sd100, 1'b1);
      send_dim(16'sd300, 16'sd100, -16'sd100, 1'b1);
      send_dim(16'sd10, 16'sd0, 16'sd100, 1'b0);
      send_dim(-16'sd50, -16'sd40, 16'sd40, 1'b0);
      send_dim(16'sd7, 16'sd7, 16'sd7, 1'b1);
   endtask

   // A seventeen-dimension pair at the field extremes drives both sums to saturation.
   task automatic test_sum_saturation();
      for (int d = 0; d < 17; d++) begin
         send_dim(COORD_MIN, COORD_MAX, COORD_MAX, d == 16);
      end
   endtask

   // Random point-box pairs, mostly of up to eight dimensions, some of up to twenty.
   task automatic test_random_pairs(input int n_items, input int idle_pct, input int hold_pct);
      int sent, dims, k, span;
      logic signed [COORD_W-1:0] c, lo, hi, t;
      send_idle_pct = idle_pct;
      stall_pct = hold_pct;
      sent = 0;
      while (sent < n_items) begin
         k = $urandom_range(99, 0);
         if (k < 85) dims = $urandom_range(8, 1);
         else if (k < 95) dims = $urandom_range(12, 9);
         else dims = $urandom_range(20, 13);
         for (int d = 0; d < dims; d++) begin
            lo = pick_coord();
            hi = pick_coord();
            // Most boxes are made proper; the rest may stay inverted.
            if ($urandom_range(9, 0) != 0 && lo > hi) begin
               t = lo;
               lo = hi;
               hi = t;
            end
            k = $urandom_range(9, 0);
            if (k < 3 && lo <= hi) begin
               span = int'(hi) - int'(lo);
               c = COORD_W'(int'(lo) + int'($urandom_range(span, 0)));
            end else if (k == 3) begin
               c = COORD_W'((int'(lo) + int'(hi)) / 2);
            end else begin
               c = pick_coord();
            end
            send_dim(c, lo, hi, d == dims - 1);
            sent++;
         end
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_req = 150;
      for (int i = 0; i < 40; i++) begin
         send_dim(pick_coord(), pick_coord(), pick_coord(), 1'b1);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_sum_saturation();
      test_random_pairs(180, 0, 0);
      test_random_pairs(180, 48, 0);
      test_random_pairs(180, 0, 48);
      test_random_pairs(180, 32, 32);
      test_backpressure();
      req_valid <= 1'b0;
      while (pending_metrics.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("point_box_nn_distance_metrics test passed");
      end else begin
         $display("point_box_nn_distance_metrics test failed");
      end
      $finish;
   end

endmodule
